### hw/rtl/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types, widths and micro-op codes for the interpolation search engine.
// ----------------------------------------------------------------------------
package ise_pkg;

  // table geometry
  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int DataW      = 32;
  localparam int LenW       = IdxW + 1;
  // signed window bound: holds -1 up to TableDepth
  localparam int PtrW       = IdxW + 2;
  localparam int ProdW      = IdxW + DataW;
  // quotient never exceeds high-low, so IdxW restoring steps suffice
  localparam int DivSteps   = IdxW;
  localparam int CntW       = $clog2(DivSteps);
  localparam int PcW        = 4;
  localparam int PaddrW     = 3;

  localparam logic [LenW-1:0] LenReset = LenW'(16);
  localparam logic [LenW-1:0] LenMax   = LenW'(TableDepth);

  // command codes
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSearch = 1'b1;

  // config register indexes
  localparam logic RegTableLength = 1'b0;

  // memory read address select
  localparam logic [1:0] RdNone = 2'd0;
  localparam logic [1:0] RdLow  = 2'd1;
  localparam logic [1:0] RdHigh = 2'd2;
  localparam logic [1:0] RdPos  = 2'd3;

  // datapath operations
  localparam logic [2:0] AluNone  = 3'd0;
  localparam logic [2:0] AluPrep  = 3'd1;
  localparam logic [2:0] AluMul   = 3'd2;
  localparam logic [2:0] AluDiv   = 3'd3;
  localparam logic [2:0] AluPos   = 3'd4;
  localparam logic [2:0] AluFlat  = 3'd5;
  localparam logic [2:0] AluStep  = 3'd6;

  // jump conditions
  localparam logic [2:0] CondNever   = 3'd0;
  localparam logic [2:0] CondAlways  = 3'd1;
  localparam logic [2:0] CondEmpty   = 3'd2;
  localparam logic [2:0] CondOutside = 3'd3;
  localparam logic [2:0] CondFlat    = 3'd4;
  localparam logic [2:0] CondDivMore = 3'd5;
  localparam logic [2:0] CondHit     = 3'd6;

  // program addresses
  localparam logic [PcW-1:0] PcCheck = PcW'(0);
  localparam logic [PcW-1:0] PcDiv   = PcW'(6);
  localparam logic [PcW-1:0] PcFlat  = PcW'(8);
  localparam logic [PcW-1:0] PcRdPos = PcW'(9);
  localparam logic [PcW-1:0] PcMiss  = PcW'(13);
  localparam logic [PcW-1:0] PcHit   = PcW'(14);

  // one control word of the microprogram
  typedef struct packed {
    logic [1:0]     rd_sel;
    logic           ld_alo;
    logic           ld_ahi;
    logic           ld_ap;
    logic [2:0]     alu;
    logic [2:0]     cond;
    logic [PcW-1:0] target;
    logic           emit_hit;
    logic           emit_miss;
    logic           fin;
  } ise_ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic empty;
    logic outside;
    logic flat;
    logic div_more;
    logic hit;
  } ise_status_t;

endpackage

### hw/rtl/ise_ucode_rom.sv
// ----------------------------------------------------------------------------
// ise_ucode_rom
// Read-only microprogram: one control word per step of a search.
// ----------------------------------------------------------------------------
module ise_ucode_rom (
  input  logic [ise_pkg::PcW-1:0] pc,
  output ise_pkg::ise_ctrl_t      ctrl
);
  import ise_pkg::*;

  // control word table
  always_comb begin
    ctrl = '{rd_sel: RdNone, ld_alo: 1'b0, ld_ahi: 1'b0, ld_ap: 1'b0, alu: AluNone,
             cond: CondNever, target: PcCheck, emit_hit: 1'b0, emit_miss: 1'b0,
             fin: 1'b0};
    case (pc)
      PcW'(0): begin
        // read a[low], leave when the window is empty
        ctrl.rd_sel = RdLow;
        ctrl.cond   = CondEmpty;
        ctrl.target = PcMiss;
      end
      PcW'(1): begin
        ctrl.rd_sel = RdHigh;
        ctrl.ld_alo = 1'b1;
      end
      PcW'(2): begin
        ctrl.ld_ahi = 1'b1;
      end
      PcW'(3): begin
        // key outside [a[low], a[high]]
        ctrl.alu    = AluPrep;
        ctrl.cond   = CondOutside;
        ctrl.target = PcMiss;
      end
      PcW'(4): begin
        ctrl.cond   = CondFlat;
        ctrl.target = PcFlat;
      end
      PcW'(5): begin
        ctrl.alu = AluMul;
      end
      PcW'(6): begin
        ctrl.alu    = AluDiv;
        ctrl.cond   = CondDivMore;
        ctrl.target = PcDiv;
      end
      PcW'(7): begin
        ctrl.alu    = AluPos;
        ctrl.cond   = CondAlways;
        ctrl.target = PcRdPos;
      end
      PcW'(8): begin
        // equal ends: probe at low
        ctrl.alu = AluFlat;
      end
      PcW'(9): begin
        ctrl.rd_sel = RdPos;
      end
      PcW'(10): begin
        ctrl.ld_ap = 1'b1;
      end
      PcW'(11): begin
        ctrl.alu    = AluStep;
        ctrl.cond   = CondHit;
        ctrl.target = PcHit;
      end
      PcW'(12): begin
        ctrl.cond   = CondAlways;
        ctrl.target = PcCheck;
      end
      PcW'(13): begin
        ctrl.emit_miss = 1'b1;
        ctrl.fin       = 1'b1;
      end
      PcW'(14): begin
        ctrl.emit_hit = 1'b1;
        ctrl.fin      = 1'b1;
      end
      default: begin
        ctrl.emit_miss = 1'b1;
        ctrl.fin       = 1'b1;
      end
    endcase
  end

endmodule

### hw/rtl/ise_datapath.sv
// ----------------------------------------------------------------------------
// ise_datapath
// Table memory, search window registers, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module ise_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [ise_pkg::IdxW-1:0]       wr_idx,
  input  logic                           init,
  input  logic signed [ise_pkg::DataW-1:0] data_in,
  input  logic [ise_pkg::LenW-1:0]       table_length,
  input  ise_pkg::ise_ctrl_t             ctrl,
  output ise_pkg::ise_status_t           status,
  output logic                           out_valid,
  output logic                           out_found,
  output logic [ise_pkg::IdxW-1:0]       out_found_index
);
  import ise_pkg::*;

  logic [DataW-1:0]        mem [TableDepth];
  logic [DataW-1:0]        rd_r;
  logic [IdxW-1:0]         rd_addr;

  logic signed [DataW-1:0] key_r;
  logic signed [DataW-1:0] alo_r;
  logic signed [DataW-1:0] ahi_r;
  logic signed [DataW-1:0] ap_r;
  logic signed [PtrW-1:0]  low_r, low_nxt;
  logic signed [PtrW-1:0]  high_r, high_nxt;
  logic [IdxW-1:0]         pos_r, pos_nxt;
  logic [IdxW-1:0]         span_r;
  logic [DataW-1:0]        off_r;
  logic [DataW-1:0]        den_r;
  logic [ProdW-1:0]        num_r, num_nxt;
  logic [IdxW-1:0]         quo_r, quo_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;

  logic [LenW-1:0]         len_clip;
  logic [ProdW-1:0]        den_sh;
  logic [IdxW:0]           pos_sum;
  logic signed [PtrW-1:0]  pos_ext;
  logic                    out_valid_r, out_found_r;
  logic [IdxW-1:0]         out_idx_r;

  // table memory, one write and one registered read per cycle
  always_comb begin
    case (ctrl.rd_sel)
      RdLow:   rd_addr = low_r[IdxW-1:0];
      RdHigh:  rd_addr = high_r[IdxW-1:0];
      RdPos:   rd_addr = pos_r;
      default: rd_addr = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= data_in;
    end
    rd_r <= mem[rd_addr];
  end

  // length clipped to the table depth
  assign len_clip = (table_length > LenMax) ? LenMax : table_length;

  // divider trial subtrahend and probe sum
  assign den_sh  = ProdW'(den_r) << cnt_r;
  assign pos_sum = {1'b0, low_r[IdxW-1:0]} + {1'b0, quo_r};
  assign pos_ext = PtrW'({1'b0, pos_r});

  // window, divider and probe next values
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    pos_nxt  = pos_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (init) begin
      low_nxt  = '0;
      high_nxt = PtrW'({1'b0, len_clip}) - PtrW'(1);
    end
    case (ctrl.alu)
      AluMul: begin
        num_nxt = ProdW'(span_r) * ProdW'(off_r);
        quo_nxt = '0;
        cnt_nxt = CntW'(DivSteps - 1);
      end
      AluDiv: begin
        if (num_r >= den_sh) begin
          num_nxt = num_r - den_sh;
          quo_nxt = quo_r | (IdxW'(1) << cnt_r);
        end
        cnt_nxt = cnt_r - CntW'(1);
      end
      AluPos: begin
        if ($signed({1'b0, pos_sum}) > high_r) begin
          pos_nxt = high_r[IdxW-1:0];
        end else begin
          pos_nxt = pos_sum[IdxW-1:0];
        end
      end
      AluFlat: begin
        pos_nxt = low_r[IdxW-1:0];
      end
      AluStep: begin
        if (key_r > ap_r) begin
          low_nxt = pos_ext + PtrW'(1);
        end else if (key_r < ap_r) begin
          high_nxt = pos_ext - PtrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (init) begin
      key_r <= data_in;
    end
    if (ctrl.ld_alo) begin
      alo_r <= rd_r;
    end
    if (ctrl.ld_ahi) begin
      ahi_r <= rd_r;
    end
    if (ctrl.ld_ap) begin
      ap_r <= rd_r;
    end
    if (ctrl.alu == AluPrep) begin
      span_r <= IdxW'(high_r - low_r);
      off_r  <= DataW'(key_r - alo_r);
      den_r  <= DataW'(ahi_r - alo_r);
    end
    low_r  <= low_nxt;
    high_r <= high_nxt;
    pos_r  <= pos_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

  // flags for the sequencer
  assign status.empty    = (low_r > high_r);
  assign status.outside  = (key_r < alo_r) || (key_r > ahi_r);
  assign status.flat     = (ahi_r == alo_r);
  assign status.div_more = (cnt_r != '0);
  assign status.hit      = (key_r == ap_r);

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit_hit || ctrl.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= ctrl.emit_hit;
    out_idx_r   <= ctrl.emit_hit ? pos_r : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_idx_r;

endmodule

### hw/rtl/interpolation_search_engine_core.sv
// ----------------------------------------------------------------------------
// interpolation_search_engine_core
// Interpolation search over a 1024-entry table of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. in_command selects
//   a table write (in_entry_index, in_data_value) or a search for the key in
//   in_data_value over entries 0 to table_length-1 (table_length clipped to
//   1024, set through the APB port at address 0, reset value 16).
//   A write completes in the cycle it is taken and gives no result; busy
//   stays low. A search raises busy and a microprogram walks the probes.
//   Each probe reads a[low], a[high] and a[pos] through the single table
//   read port and computes the probe with a 10x32 multiply and a 10-step
//   restoring divider; when the window ends are equal the probe is taken
//   at low without the multiply and divide. The window test ends a miss on
//   an empty window or on a key outside [a[low], a[high]].
//   One more step finishes, and the result beat follows in the next cycle:
//   out_valid high for one cycle with out_found and out_found_index (zero on
//   a miss) as busy falls, so the probe count sets the search time.
//   The receiver cannot stall; results are never held. Reset clears the
//   sequencer, sets table_length to 16; table data is undefined until written.
// ----------------------------------------------------------------------------
module interpolation_search_engine_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [ise_pkg::IdxW-1:0]          in_entry_index,
  input  logic signed [ise_pkg::DataW-1:0]  in_data_value,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [ise_pkg::IdxW-1:0]          out_found_index,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ise_pkg::PaddrW-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import ise_pkg::*;

  logic [LenW-1:0] len_r;
  logic            busy_r, busy_nxt;
  logic [PcW-1:0]  pc_r, pc_nxt;
  ise_ctrl_t       rom_ctrl, ctrl;
  ise_status_t     status;
  logic            take, wr_en, init, jump;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LenReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegTableLength)) begin
      len_r <= pwdata[LenW-1:0];
    end
  end
  assign prdata = (paddr[2] == RegTableLength) ? {{(32-LenW){1'b0}}, len_r} : '0;

  // command intake
  assign take  = start && !busy_r;
  assign wr_en = take && (in_command == CmdWrite);
  assign init  = take && (in_command == CmdSearch);

  // microprogram store
  ise_ucode_rom u_rom (
    .pc   (pc_r),
    .ctrl (rom_ctrl)
  );

  // idle cycles issue no operation
  always_comb begin
    ctrl = rom_ctrl;
    if (!busy_r) begin
      ctrl.rd_sel    = RdNone;
      ctrl.ld_alo    = 1'b0;
      ctrl.ld_ahi    = 1'b0;
      ctrl.ld_ap     = 1'b0;
      ctrl.alu       = AluNone;
      ctrl.cond      = CondNever;
      ctrl.emit_hit  = 1'b0;
      ctrl.emit_miss = 1'b0;
      ctrl.fin       = 1'b0;
    end
  end

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      CondAlways:  jump = 1'b1;
      CondEmpty:   jump = status.empty;
      CondOutside: jump = status.outside;
      CondFlat:    jump = status.flat;
      CondDivMore: jump = status.div_more;
      CondHit:     jump = status.hit;
      default:     jump = 1'b0;
    endcase
  end

  // step counter and busy flag
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (init) begin
      busy_nxt = 1'b1;
      pc_nxt   = PcCheck;
    end else if (busy_r) begin
      if (ctrl.fin) begin
        busy_nxt = 1'b0;
        pc_nxt   = PcCheck;
      end else if (jump) begin
        pc_nxt = ctrl.target;
      end else begin
        pc_nxt = pc_r + PcW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PcCheck;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy = busy_r;

  ise_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_en           (wr_en),
    .wr_idx          (in_entry_index),
    .init            (init),
    .data_in         (in_data_value),
    .table_length    (len_r),
    .ctrl            (ctrl),
    .status          (status),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_found_index (out_found_index)
  );

endmodule
